>>> src/sfa_pkg.sv
// Shared types, constants and helpers for the swap frame allocator.
package sfa_pkg;

  localparam int FRAMES        = 16;
  localparam int IDX_W         = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W         = $clog2(FRAMES + 1);

  localparam int ASID_W        = 4;
  localparam int PAGE_IN_W     = 8;
  localparam int PAGE_W        = 5;
  localparam int FRAME_INDEX_W = 4;
  localparam int ADDR_W        = 32;
  localparam int FRAME_SHIFT   = 12;

  localparam int LAST_PLAIN_PAGE = 30;
  localparam int STACK_PAGE      = 31;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 48;

  localparam logic OP_FAULT   = 1'b0;
  localparam logic OP_CLEANUP = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic              used;
    logic [ASID_W-1:0] owner;
    logic [PAGE_W-1:0] page;
  } frame_entry_t;

  typedef struct packed {
    logic         wr_en;
    idx_t         wr_addr;
    frame_entry_t wr_data;
    idx_t         rd_addr;
  } table_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]        victim_page;
    logic [ASID_W-1:0]        victim_asid;
    logic                     victim_valid;
    logic [ADDR_W-1:0]        frame_address;
    logic [FRAME_INDEX_W-1:0] frame_index;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VICTIM_RD,
    ST_VICTIM_CHK,
    ST_CLEAN,
    ST_DONE
  } ctrl_state_t;

  // Circular step over the frame table.
  function automatic idx_t idx_inc(input idx_t i);
    idx_t r;
    if (i == IDX_W'(FRAMES - 1)) r = '0;
    else r = IDX_W'(i + 1'b1);
    return r;
  endfunction

endpackage

>>> src/sfa_frame_table.sv
// Frame table memory: one write and one registered read per cycle, with reset valid flags.
module sfa_frame_table (
  input  logic                  clk,
  input  logic                  rst,
  input  sfa_pkg::table_req_t   req,
  output sfa_pkg::frame_entry_t rd_entry
);
  import sfa_pkg::*;

  frame_entry_t      mem [FRAMES];
  logic [FRAMES-1:0] vld;
  frame_entry_t      rd_data;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

  // an entry never written reads as a free, zeroed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      rd_vld <= vld[req.rd_addr];
    end
  end

  assign rd_entry = rd_vld ? rd_data : '0;

endmodule

>>> src/sfa_ctrl.sv
// Sequencer: scans the frame table, picks free or victim frame, handles cleanup.
module sfa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [sfa_pkg::ASID_W-1:0]    in_asid,
  input  logic [sfa_pkg::PAGE_IN_W-1:0] in_page,
  input  logic [sfa_pkg::ADDR_W-1:0]    swap_base,
  input  sfa_pkg::frame_entry_t         rd_entry,
  output sfa_pkg::table_req_t           req,
  input  logic                          res_ready,
  output logic                          res_valid,
  output sfa_pkg::result_t              res
);
  import sfa_pkg::*;

  ctrl_state_t       state, state_next;
  logic              op_q, op_q_next;
  logic [ASID_W-1:0] asid_q, asid_q_next;
  logic [PAGE_W-1:0] page_q, page_q_next;
  idx_t              ptr, ptr_next;
  idx_t              rd_idx, rd_idx_next;
  logic [CNT_W-1:0]  issued, issued_next;
  logic              chk_vld, chk_vld_next;
  idx_t              chk_idx, chk_idx_next;
  logic              chk_last, chk_last_next;
  idx_t              sel, sel_next;
  logic              vic_used, vic_used_next;
  logic [ASID_W-1:0] vic_owner, vic_owner_next;
  logic [PAGE_W-1:0] vic_page, vic_page_next;
  logic              issue_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ptr     <= '0;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      chk_vld <= chk_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q      <= op_q_next;
    asid_q    <= asid_q_next;
    page_q    <= page_q_next;
    rd_idx    <= rd_idx_next;
    issued    <= issued_next;
    chk_idx   <= chk_idx_next;
    chk_last  <= chk_last_next;
    sel       <= sel_next;
    vic_used  <= vic_used_next;
    vic_owner <= vic_owner_next;
    vic_page  <= vic_page_next;
  end

  assign issue_ok = (issued < CNT_W'(FRAMES));

  always_comb begin
    state_next     = state;
    op_q_next      = op_q;
    asid_q_next    = asid_q;
    page_q_next    = page_q;
    ptr_next       = ptr;
    rd_idx_next    = rd_idx;
    issued_next    = issued;
    chk_vld_next   = 1'b0;
    chk_idx_next   = chk_idx;
    chk_last_next  = chk_last;
    sel_next       = sel;
    vic_used_next  = vic_used;
    vic_owner_next = vic_owner;
    vic_page_next  = vic_page;
    in_ready       = 1'b0;
    req            = '0;
    req.rd_addr    = rd_idx;
    res_valid      = 1'b0;
    res            = '0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_q_next   = in_op;
          asid_q_next = in_asid;
          if (in_page > PAGE_IN_W'(LAST_PLAIN_PAGE)) page_q_next = PAGE_W'(STACK_PAGE);
          else page_q_next = in_page[PAGE_W-1:0];
          issued_next = '0;
          if (in_op == OP_FAULT) begin
            rd_idx_next = ptr;
            state_next  = ST_SCAN;
          end else begin
            rd_idx_next = '0;
            state_next  = ST_CLEAN;
          end
        end
      end

      // reads go out every cycle, the entry read last cycle is checked
      ST_SCAN: begin
        if (chk_vld && !rd_entry.used) begin
          sel_next       = chk_idx;
          vic_used_next  = 1'b0;
          vic_owner_next = '0;
          vic_page_next  = '0;
          state_next     = ST_DONE;
        end else if (chk_vld && chk_last) begin
          state_next = ST_VICTIM_RD;
        end else if (issue_ok) begin
          req.rd_addr   = rd_idx;
          rd_idx_next   = idx_inc(rd_idx);
          issued_next   = CNT_W'(issued + 1'b1);
          chk_vld_next  = 1'b1;
          chk_idx_next  = rd_idx;
          chk_last_next = (issued == CNT_W'(FRAMES - 1));
        end
      end

      // table full: the frame after the pointer is evicted
      ST_VICTIM_RD: begin
        req.rd_addr = idx_inc(ptr);
        sel_next    = idx_inc(ptr);
        state_next  = ST_VICTIM_CHK;
      end

      ST_VICTIM_CHK: begin
        vic_used_next  = rd_entry.used;
        vic_owner_next = rd_entry.used ? rd_entry.owner : '0;
        vic_page_next  = rd_entry.used ? rd_entry.page : '0;
        state_next     = ST_DONE;
      end

      ST_CLEAN: begin
        if (chk_vld && rd_entry.used && (rd_entry.owner == asid_q)) begin
          req.wr_en         = 1'b1;
          req.wr_addr       = chk_idx;
          req.wr_data       = rd_entry;
          req.wr_data.used  = 1'b0;
        end
        if (chk_vld && chk_last) begin
          state_next = ST_DONE;
        end else if (issue_ok) begin
          req.rd_addr   = rd_idx;
          rd_idx_next   = idx_inc(rd_idx);
          issued_next   = CNT_W'(issued + 1'b1);
          chk_vld_next  = 1'b1;
          chk_idx_next  = rd_idx;
          chk_last_next = (issued == CNT_W'(FRAMES - 1));
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
          if (op_q == OP_FAULT) begin
            req.wr_en            = 1'b1;
            req.wr_addr          = sel;
            req.wr_data.used     = 1'b1;
            req.wr_data.owner    = asid_q;
            req.wr_data.page     = page_q;
            ptr_next             = sel;
            res.frame_index      = FRAME_INDEX_W'(sel);
            res.frame_address    = swap_base + (ADDR_W'(sel) << FRAME_SHIFT);
            res.victim_valid     = vic_used;
            res.victim_asid      = vic_owner;
            res.victim_page      = vic_page;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/swap_frame_allocator_unit.sv
// Swap frame allocator top level: stream ports, base register, result register.
//
// Usage:
//   Slave stream carries one request item: s_tuser is the opcode (0 = page
//   fault, 1 = free every frame of an asid), s_tdata holds asid and page.
//   Master stream returns one result item per request: frame index, frame
//   address (swap_base + index * 4096), and victim flag, owner and page.
//   swap_base (cfg_wr_en/cfg_wr_data): user writes only while idle; unenforced.
// Timing:
//   One request is worked on at a time. The frame table is a one-read,
//   one-write memory scanned at one entry per cycle; a fault stops at the
//   first free frame, or on a full table reads back the victim, and a
//   cleanup examines every entry.
// Reset:
//   rst (synchronous) marks every frame free, clears the search pointer,
//   swap_base and the result valid flag; no clearing pass is needed.
// Backpressure:
//   A finished result sits in the output register until m_tready; the
//   next request can be taken meanwhile, and its result waits in turn.
module swap_frame_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [sfa_pkg::ADDR_W-1:0]      cfg_wr_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [3:0] asid, [11:4] page, [15:12] zero
  input  logic [sfa_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] opcode
  input  logic [sfa_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] frame_index, [35:4] frame_address, [36] victim_valid,
  // [40:37] victim_asid, [45:41] victim_page, [47:46] zero
  output logic [sfa_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import sfa_pkg::*;

  logic [ADDR_W-1:0] swap_base;
  table_req_t        tbl_req;
  frame_entry_t      rd_entry;
  logic              res_ready;
  logic              res_valid;
  result_t           res;
  logic              out_valid;
  result_t           out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_base <= '0;
    end else if (cfg_wr_en) begin
      swap_base <= cfg_wr_data;
    end
  end

  sfa_frame_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rd_entry (rd_entry)
  );

  sfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser[0]),
    .in_asid   (s_tdata[ASID_W-1:0]),
    .in_page   (s_tdata[ASID_W+PAGE_IN_W-1:ASID_W]),
    .swap_base (swap_base),
    .rd_entry  (rd_entry),
    .req       (tbl_req),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_res);

  // one request in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in progress");

  // a result never appears in the cycle right after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !res_valid)
    else $error("result produced without any table scan");

  // a new result never overwrites one still waiting downstream
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || m_tready))
    else $error("result issued while output register is held");

  // table writes never collide with a read of the same entry during cleanup
  assert property (@(posedge clk) disable iff (rst)
    tbl_req.wr_en && !res_valid |-> tbl_req.wr_addr != tbl_req.rd_addr)
    else $error("cleanup write hits the entry being read");

endmodule

>>> tb/sfa_checker.sv
// Frame table tracker: predicts every result item of the allocator and compares it.
module sfa_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [sfa_pkg::ADDR_W-1:0]      cfg_wr_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [sfa_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [sfa_pkg::IN_TUSER_W-1:0]  s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [sfa_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              fail_count,
  output int                              outstanding,
  output int                              victim_count
);
  import sfa_pkg::*;

  logic [ADDR_W-1:0] pool_base;
  logic              slot_busy  [FRAMES];
  logic [ASID_W-1:0] slot_asid  [FRAMES];
  logic [PAGE_W-1:0] slot_vpage [FRAMES];
  idx_t              scan_ptr;
  result_t           frame_grants_q[$];
  int                fails;
  int                victims;

  initial begin
    fails = 0;
    victims = 0;
    fail_count = 0;
    outstanding = 0;
    victim_count = 0;
  end

  // Applies one request to the tracked table and returns the result item it should give.
  function automatic result_t serve_request(input logic op, input logic [ASID_W-1:0] asid,
                                            input logic [PAGE_IN_W-1:0] page_in);
    result_t           r;
    logic [PAGE_W-1:0] vpage;
    int                i;
    int                k;
    bit                found;
    r = '0;
    if (op == OP_CLEANUP) begin
      for (i = 0; i < FRAMES; i++)
        if (slot_busy[i] && slot_asid[i] == asid) slot_busy[i] = 1'b0;
      return r;
    end
    vpage = (page_in > PAGE_IN_W'(LAST_PLAIN_PAGE)) ? PAGE_W'(STACK_PAGE)
                                                   : page_in[PAGE_W-1:0];
    found = 1'b0;
    k = 0;
    for (i = 0; i < FRAMES; i++) begin
      if (!found && !slot_busy[(int'(scan_ptr) + i) % FRAMES]) begin
        found = 1'b1;
        k = (int'(scan_ptr) + i) % FRAMES;
      end
    end
    // pointer rests on the frame just taken; on a full table it steps to the victim
    if (!found) k = (int'(scan_ptr) + 1) % FRAMES;
    scan_ptr = idx_t'(k);
    r.frame_index = FRAME_INDEX_W'(k);
    r.frame_address = pool_base + (ADDR_W'(k) << FRAME_SHIFT);
    if (slot_busy[k]) begin
      r.victim_valid = 1'b1;
      r.victim_asid = slot_asid[k];
      r.victim_page = slot_vpage[k];
    end
    slot_busy[k] = 1'b1;
    slot_asid[k] = asid;
    slot_vpage[k] = vpage;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want_v,
                             input logic [ADDR_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    int      i;
    if (rst) begin
      pool_base = '0;
      scan_ptr = '0;
      for (i = 0; i < FRAMES; i++) begin
        slot_busy[i] = 1'b0;
        slot_asid[i] = '0;
        slot_vpage[i] = '0;
      end
      frame_grants_q.delete();
    end else begin
      if (cfg_wr_en) pool_base = cfg_wr_data;
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(result_t)-1:0];
        if (frame_grants_q.size() == 0) begin
          $display("%0t: result item with nothing expected, expected none, actual %h",
                   $time, m_tdata);
          fails++;
        end else begin
          want = frame_grants_q.pop_front();
          if (want.victim_valid) victims++;
          check_field("frame_index", ADDR_W'(want.frame_index), ADDR_W'(got.frame_index));
          check_field("frame_address", want.frame_address, got.frame_address);
          check_field("victim_valid", ADDR_W'(want.victim_valid), ADDR_W'(got.victim_valid));
          check_field("victim_asid", ADDR_W'(want.victim_asid), ADDR_W'(got.victim_asid));
          check_field("victim_page", ADDR_W'(want.victim_page), ADDR_W'(got.victim_page));
          check_field("tdata padding", '0,
                      ADDR_W'(m_tdata[OUT_TDATA_W-1:$bits(result_t)]));
        end
      end
      if (s_tvalid && s_tready)
        frame_grants_q.push_back(serve_request(s_tuser[0], s_tdata[ASID_W-1:0],
                                               s_tdata[ASID_W +: PAGE_IN_W]));
    end
    fail_count <= fails;
    outstanding <= frame_grants_q.size();
    victim_count <= victims;
  end

endmodule

>>> tb/tb_top.sv
// Testbench top: clock, reset, request stimulus, result backpressure and verdict.
module tb_top;
  import sfa_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = FRAMES + 8;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 200;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0]      cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int victim_count;
  int cycle_count = 0;
  int burst_left = 0;
  int items_sent = 0;
  int cleanups_sent = 0;
  int base_writes = 0;
  bit rx_hold_req = 1'b0;

  swap_frame_allocator_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  sfa_checker frame_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .victim_count (victim_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one request item and waits for it to be taken; bursts end in random gaps.
  task automatic send_item(input logic op, input logic [ASID_W-1:0] asid,
                           input logic [PAGE_IN_W-1:0] page);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= IN_TDATA_W'({page, asid});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == OP_CLEANUP) cleanups_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Mostly well-behaved processes with plain pages; now and then odd asids and high pages.
  task automatic send_random(input int cleanup_odds);
    logic                 op;
    logic [ASID_W-1:0]    asid;
    logic [PAGE_IN_W-1:0] page;
    op = ($urandom_range(0, cleanup_odds - 1) == 0) ? OP_CLEANUP : OP_FAULT;
    asid = ($urandom_range(0, 15) == 0) ? ASID_W'($urandom_range(0, 15))
                                        : ASID_W'($urandom_range(1, 8));
    page = ($urandom_range(0, 5) == 0) ? PAGE_IN_W'($urandom)
                                       : PAGE_IN_W'($urandom_range(0, 30));
    send_item(op, asid, page);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_writes++;
  endtask

  // Result side: switches among random stall patterns; long hold-off on request.
  initial begin : rx_side
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        hold = 0;
        while (hold < HOLD_CYCLES) begin
          @(posedge clk);
          hold++;
        end
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(50, 400);
        end
        left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [PAGE_IN_W-1:0] dir_pages [16];
    logic [ADDR_W-1:0]    base;
    int                   f;
    int                   phase;
    int                   n;
    dir_pages = '{8'd0, 8'd30, 8'd31, 8'd255, 8'd128, 8'd5, 8'd12, 8'd29,
                  8'd1, 8'd2, 8'd64, 8'd19, 8'd7, 8'd23, 8'd250, 8'd11};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every frame at the reset base, then force evictions and cleanups
    for (f = 0; f < FRAMES; f++)
      send_item(OP_FAULT, ASID_W'((f % 8) + 1), dir_pages[f]);
    send_item(OP_FAULT, 4'd15, 8'd3);
    send_item(OP_FAULT, 4'd0, 8'd31);
    send_item(OP_CLEANUP, 4'd3, 8'd0);
    send_item(OP_CLEANUP, 4'd12, 8'd255);
    send_item(OP_FAULT, 4'd5, 8'd40);
    send_item(OP_CLEANUP, 4'd15, 8'd0);
    send_item(OP_CLEANUP, 4'd0, 8'd0);
    send_item(OP_FAULT, 4'd8, 8'd30);

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: base = 32'hFFFF_FFFF;
        1: base = 32'h0000_0000;
        2: base = 32'hFFFF_F000;
        3: base = 32'h8000_0000;
        default: base = $urandom;
      endcase
      write_base(base);
      if (phase == 1) begin
        // result side blocks while requests keep coming, so the input has to stall
        rx_hold_req = 1'b1;
        burst_left = 60;
        repeat (40) send_random(8);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random((phase % 2 == 1) ? 20 : 6);
        if (n % 50 == 49 && $urandom_range(0, 1) == 1) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d cleanups) over %0d base settings in %0d cycles",
             items_sent, cleanups_sent, base_writes + 1, cycle_count);
    $display("Saw %0d evictions; table filled, wrapped and emptied by asid", victim_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
